// ===== rtl/core/rbnp_pkg.sv =====
// ----------------------------------------------------------------------------
// rbnp_pkg: shared types and constants for the ray/box nearest pick block
// Field widths, configuration register indexes, reset values, and the
// structures passed between the front, the queue and the back.
// ----------------------------------------------------------------------------
package rbnp_pkg;

    // Default list capacity and classification queue depth.
    localparam int unsigned MAX_BOXES_DEF = 1024;
    localparam int unsigned QUEUE_DEPTH   = 8;

    // Field widths.
    localparam int unsigned COORD_W = 32;               // Q16.16 coordinate
    localparam int unsigned DIR_W   = 18;               // Q2.16 ranking direction
    localparam int unsigned DIFF_W  = COORD_W + 1;      // bound minus origin
    localparam int unsigned PROD_W  = DIFF_W + COORD_W; // full slab product
    localparam int unsigned SLAB_W  = 64;               // Q32.32 slab distance
    localparam int unsigned RANK_W  = COORD_W + DIR_W;  // rank product
    localparam int unsigned IDX_W   = 10;               // reported index
    localparam int unsigned N_AXES  = 3;
    localparam int unsigned N_LANES = 2 * N_AXES;       // near and far per axis

    // Stream widths.
    localparam int unsigned S_TDATA_W = 8 * COORD_W;
    localparam int unsigned M_TDATA_W = 16;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DIR_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z     = 3'd7;

    // Reset value of the inverse direction: largest positive Q16.16.
    localparam logic [COORD_W-1:0] INV_DIR_RESET = 32'h7FFF_FFFF;

    // Ray setup held by the configuration registers.
    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] origin_z;
        logic [COORD_W-1:0] inv_x;
        logic [COORD_W-1:0] inv_y;
        logic [COORD_W-1:0] inv_z;
        logic [DIR_W-1:0]   dir_x;
        logic [DIR_W-1:0]   dir_z;
    } t_ray;

    // One classified box as handed from the front to the back.
    typedef struct packed {
        logic              hit;
        logic [RANK_W-1:0] rank_x;
        logic [RANK_W-1:0] rank_z;
        logic              last;
    } t_cls;

endpackage

// ===== rtl/core/ray_box_nearest_pick.sv =====
// ----------------------------------------------------------------------------
// ray_box_nearest_pick: nearest hit box along a fixed ray
// Runs the slab test on a stream of boxes and reports, at the end of each
// list, whether a box was taken and its list position.
// ----------------------------------------------------------------------------
// Throughput: one box per cycle while the result output is not stalled; the slab
//   pipeline and the pick logic then each handle a box every cycle, joined by a
//   queue of Q_DEPTH entries. Result path: the last box passes the 3 slab stages,
//   the queue and the result register before the result is valid.
// Reset: synchronous, active low; clears the list state, the pipeline and the
//   queue, and returns the ray registers to their reset values.
module ray_box_nearest_pick #(
    parameter int unsigned MAX_BOXES = rbnp_pkg::MAX_BOXES_DEF,
    parameter int unsigned Q_DEPTH   = rbnp_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [rbnp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rbnp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Box stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from the lowest bit: box_min_x, box_min_y, box_min_z,
    // box_max_x, box_max_y, box_max_z, center_x, center_z.
    input  logic [rbnp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // Field: last_box.
    input  logic                               s_axis_tlast,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from the lowest bit: picked_index, zero padding.
    output logic [rbnp_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // Fields from the lowest bit: found.
    output logic                               m_axis_tuser
);
    import rbnp_pkg::*;

    localparam int unsigned QCW = $clog2(Q_DEPTH + 1);

    t_ray             r_ray;
    logic             w_accept;
    logic             w_push;
    t_cls             w_push_data;
    logic [1:0]       w_busy;
    t_cls             w_q_data;
    logic             w_q_valid;
    logic             w_q_pop;
    logic [QCW-1:0]   w_q_count;
    logic [QCW:0]     w_credit_used;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray.origin_x <= '0;
            r_ray.origin_y <= '0;
            r_ray.origin_z <= '0;
            r_ray.inv_x    <= INV_DIR_RESET;
            r_ray.inv_y    <= INV_DIR_RESET;
            r_ray.inv_z    <= INV_DIR_RESET;
            r_ray.dir_x    <= '0;
            r_ray.dir_z    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: begin
                    r_ray.origin_x <= i_cfg_data[COORD_W-1:0];
                end
                REG_ORIGIN_Y: begin
                    r_ray.origin_y <= i_cfg_data[COORD_W-1:0];
                end
                REG_ORIGIN_Z: begin
                    r_ray.origin_z <= i_cfg_data[COORD_W-1:0];
                end
                REG_INV_DIR_X: begin
                    r_ray.inv_x <= i_cfg_data[COORD_W-1:0];
                end
                REG_INV_DIR_Y: begin
                    r_ray.inv_y <= i_cfg_data[COORD_W-1:0];
                end
                REG_INV_DIR_Z: begin
                    r_ray.inv_z <= i_cfg_data[COORD_W-1:0];
                end
                REG_DIR_X: begin
                    r_ray.dir_x <= i_cfg_data[DIR_W-1:0];
                end
                REG_DIR_Z: begin
                    r_ray.dir_z <= i_cfg_data[DIR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Credit: every box in the slab pipeline has a queue slot reserved.
    assign w_credit_used = (QCW+1)'(w_q_count) + (QCW+1)'(w_busy);
    assign s_axis_tready = (w_credit_used < (QCW+1)'(Q_DEPTH));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    rbnp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_tdata  (s_axis_tdata),
        .i_tlast  (s_axis_tlast),
        .i_ray    (r_ray),
        .o_push   (w_push),
        .o_cls    (w_push_data),
        .o_busy   (w_busy)
    );

    rbnp_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_valid (w_q_valid),
        .o_count (w_q_count)
    );

    rbnp_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser)
    );

    // Reserved slots never exceed the queue depth.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_credit_used <= (QCW+1)'(Q_DEPTH))
        else $error("queue credit exceeds depth");

    // A push never lands on a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_q_count != QCW'(Q_DEPTH)))
        else $error("push into full queue");

    // A list with no taken box reports index zero.
    a_none_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("nonzero index without a found box");

endmodule

// ===== rtl/core/rbnp_front.sv =====
// ----------------------------------------------------------------------------
// rbnp_front: slab test pipeline
// Three register stages classify one box per cycle: corner selection and
// origin offset, slab and rank products, then the x/y slab overlap with the
// narrowed interval. The z slab check finishes on the way into the queue.
// ----------------------------------------------------------------------------
module rbnp_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    // Fields from the lowest bit: box_min_x, box_min_y, box_min_z,
    // box_max_x, box_max_y, box_max_z, center_x, center_z.
    input  logic [rbnp_pkg::S_TDATA_W-1:0]     i_tdata,
    input  logic                               i_tlast,
    input  rbnp_pkg::t_ray                     i_ray,
    output logic                               o_push,
    output rbnp_pkg::t_cls                     o_cls,
    output logic [1:0]                         o_busy
);
    import rbnp_pkg::*;

    logic [COORD_W-1:0] w_org [N_AXES];
    logic [COORD_W-1:0] w_inv [N_AXES];

    // Stage 1 registers: offsets of the near and far bounds from the origin.
    logic                      r_v1;
    logic                      r_last1;
    logic signed [DIFF_W-1:0]  r_d [N_LANES];
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cz;

    // Stage 2 registers: slab distances and rank products.
    logic                      r_v2;
    logic                      r_last2;
    logic signed [SLAB_W-1:0]  r_t [N_LANES];
    logic signed [RANK_W-1:0]  r_rx2;
    logic signed [RANK_W-1:0]  r_rz2;
    logic signed [RANK_W-1:0]  w_rx;
    logic signed [RANK_W-1:0]  w_rz;

    // Stage 3 registers: x/y overlap and the narrowed interval.
    logic                      r_v3;
    logic                      r_last3;
    logic                      r_xy_ok;
    logic signed [SLAB_W-1:0]  r_tn;
    logic signed [SLAB_W-1:0]  r_tf;
    logic signed [SLAB_W-1:0]  r_z0;
    logic signed [SLAB_W-1:0]  r_z1;
    logic signed [RANK_W-1:0]  r_rx3;
    logic signed [RANK_W-1:0]  r_rz3;
    logic                      w_xy_ok;
    logic signed [SLAB_W-1:0]  w_tn;
    logic signed [SLAB_W-1:0]  w_tf;

    assign w_org[0] = i_ray.origin_x;
    assign w_org[1] = i_ray.origin_y;
    assign w_org[2] = i_ray.origin_z;
    assign w_inv[0] = i_ray.inv_x;
    assign w_inv[1] = i_ray.inv_y;
    assign w_inv[2] = i_ray.inv_z;

    // Per axis: a negative inverse direction swaps near and far corners.
    for (genvar a = 0; a < N_AXES; a++) begin : g_axis
        logic [COORD_W-1:0]       w_lo;
        logic [COORD_W-1:0]       w_hi;
        logic [COORD_W-1:0]       w_near;
        logic [COORD_W-1:0]       w_far;
        logic signed [DIFF_W-1:0] w_dn;
        logic signed [DIFF_W-1:0] w_df;

        assign w_lo   = i_tdata[COORD_W*a +: COORD_W];
        assign w_hi   = i_tdata[COORD_W*(a+N_AXES) +: COORD_W];
        assign w_near = w_inv[a][COORD_W-1] ? w_hi : w_lo;
        assign w_far  = w_inv[a][COORD_W-1] ? w_lo : w_hi;
        assign w_dn   = DIFF_W'($signed(w_near)) - DIFF_W'($signed(w_org[a]));
        assign w_df   = DIFF_W'($signed(w_far)) - DIFF_W'($signed(w_org[a]));

        always_ff @(posedge i_clk) begin
            if (i_accept) begin
                r_d[2*a]   <= w_dn;
                r_d[2*a+1] <= w_df;
            end
        end
    end

    // Slab products: the offset stays below 2^32 in magnitude, so the
    // product always fits the signed Q32.32 range without clamping.
    for (genvar l = 0; l < N_LANES; l++) begin : g_lane
        logic signed [PROD_W-1:0] w_p;

        assign w_p = r_d[l] * $signed(w_inv[l/2]);

        always_ff @(posedge i_clk) begin
            if (r_v1) begin
                r_t[l] <= w_p[SLAB_W-1:0];
            end
        end
    end

    assign w_rx = r_cx * $signed(i_ray.dir_x);
    assign w_rz = r_cz * $signed(i_ray.dir_z);

    // X/Y overlap test and interval narrowing.
    assign w_xy_ok = !((r_t[0] > r_t[3]) || (r_t[2] > r_t[1]));
    assign w_tn    = (r_t[2] > r_t[0]) ? r_t[2] : r_t[0];
    assign w_tf    = (r_t[3] < r_t[1]) ? r_t[3] : r_t[1];

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cx    <= $signed(i_tdata[COORD_W*6 +: COORD_W]);
            r_cz    <= $signed(i_tdata[COORD_W*7 +: COORD_W]);
            r_last1 <= i_tlast;
        end
        if (r_v1) begin
            r_rx2   <= w_rx;
            r_rz2   <= w_rz;
            r_last2 <= r_last1;
        end
        if (r_v2) begin
            r_xy_ok <= w_xy_ok;
            r_tn    <= w_tn;
            r_tf    <= w_tf;
            r_z0    <= r_t[4];
            r_z1    <= r_t[5];
            r_rx3   <= r_rx2;
            r_rz3   <= r_rz2;
            r_last3 <= r_last2;
        end
    end

    // Z slab against the narrowed interval, pushed into the queue.
    assign o_push       = r_v3;
    assign o_cls.hit    = r_xy_ok && !((r_tn > r_z1) || (r_z0 > r_tf));
    assign o_cls.rank_x = r_rx3;
    assign o_cls.rank_z = r_rz3;
    assign o_cls.last   = r_last3;

    // Items in flight, used for queue credit.
    assign o_busy = 2'(r_v1) + 2'(r_v2) + 2'(r_v3);

endmodule

// ===== rtl/core/rbnp_queue.sv =====
// ----------------------------------------------------------------------------
// rbnp_queue: classified box queue
// A small first-in first-out buffer between the slab test pipeline and the
// pick logic so that each side can stall on its own.
// ----------------------------------------------------------------------------
module rbnp_queue #(
    parameter int unsigned DEPTH = rbnp_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  rbnp_pkg::t_cls               i_data,
    input  logic                         i_pop,
    output rbnp_pkg::t_cls               o_data,
    output logic                         o_valid,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import rbnp_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cls            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap at the last entry, so depths other than powers of two work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(w_pop);
        end
    end

endmodule

// ===== rtl/core/rbnp_back.sv =====
// ----------------------------------------------------------------------------
// rbnp_back: nearest pick and result register
// Keeps the running best rank pair and box count of the list, takes the first
// hit box, then one with both ranks strictly lower; reports on the last box.
// ----------------------------------------------------------------------------
module rbnp_back #(
    parameter int unsigned MAX_BOXES = rbnp_pkg::MAX_BOXES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  rbnp_pkg::t_cls                   i_q_data,
    output logic                             o_q_pop,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    // Fields from the lowest bit: picked_index, zero padding.
    output logic [rbnp_pkg::M_TDATA_W-1:0]   o_tdata,
    // Fields from the lowest bit: found.
    output logic                             o_tuser
);
    import rbnp_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_best_idx;
    logic signed [RANK_W-1:0] r_best_x;
    logic signed [RANK_W-1:0] r_best_z;
    logic                     r_any;
    logic                     r_ovalid;
    logic                     r_found;
    logic [IDX_W-1:0]         r_idx;

    logic                     w_out_free;
    logic                     w_in_range;
    logic                     w_better;
    logic                     w_take;
    logic                     n_any;
    logic [CNT_W-1:0]         n_best_idx;
    logic [IDX_W-1:0]         w_idx;

    assign w_out_free = !r_ovalid || i_tready;
    assign o_q_pop    = i_q_valid && (!i_q_data.last || w_out_free);

    // A box is taken only while the list is under capacity and both ranks
    // beat the best pair; with nothing taken yet, the first hit box is taken.
    assign w_in_range = (r_count < CNT_W'(MAX_BOXES));
    assign w_better   = !r_any || (($signed(i_q_data.rank_x) < r_best_x) &&
                                   ($signed(i_q_data.rank_z) < r_best_z));
    assign w_take     = o_q_pop && w_in_range && i_q_data.hit && w_better;
    assign n_any      = r_any || w_take;
    assign n_best_idx = w_take ? r_count : r_best_idx;

    // Reported index is the low bits of the list position.
    if (CNT_W >= IDX_W) begin : g_idx_cut
        assign w_idx = n_best_idx[IDX_W-1:0];
    end else begin : g_idx_ext
        assign w_idx = {{(IDX_W-CNT_W){1'b0}}, n_best_idx};
    end

    // List state: updated on each box, cleared after the last box reports.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_best_idx <= '0;
            r_any      <= 1'b0;
        end else if (o_q_pop) begin
            if (i_q_data.last) begin
                r_count    <= '0;
                r_best_idx <= '0;
                r_any      <= 1'b0;
            end else begin
                r_count    <= r_count + CNT_W'(w_in_range);
                r_best_idx <= n_best_idx;
                r_any      <= n_any;
            end
        end
    end

    // Best rank pair, meaningful only while a box has been taken.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_x <= $signed(i_q_data.rank_x);
            r_best_z <= $signed(i_q_data.rank_z);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_q_pop && i_q_data.last) begin
            r_ovalid <= 1'b1;
        end else if (i_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_data.last) begin
            r_found <= n_any;
            r_idx   <= n_any ? w_idx : '0;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tuser  = r_found;
    assign o_tdata  = {{(M_TDATA_W-IDX_W){1'b0}}, r_idx};

endmodule
